### rtl/core/gap_pkg.sv
// ----------------------------------------------------------------------------
// gap_pkg
// Shared types and constants for the grid path search block.
// ----------------------------------------------------------------------------
package gap_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int NUM_CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int PATH_DEPTH = 4096;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int IDX_W      = XW + YW;
  localparam int CNT_W      = IDX_W + 1;
  localparam int PIDX_W     = $clog2(PATH_DEPTH);
  localparam int SCORE_CAP  = 65535;

  // actions
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_BLOCKED = 2'd2;

  // per-cell search status
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_OPEN   = 2'd1;
  localparam logic [1:0] ST_CLOSED = 2'd2;

  // neighbor order
  localparam logic [2:0] DIR_N  = 3'd0;
  localparam logic [2:0] DIR_S  = 3'd1;
  localparam logic [2:0] DIR_E  = 3'd2;
  localparam logic [2:0] DIR_W  = 3'd3;
  localparam logic [2:0] DIR_NE = 3'd4;
  localparam logic [2:0] DIR_NW = 3'd5;
  localparam logic [2:0] DIR_SE = 3'd6;
  localparam logic [2:0] DIR_SW = 3'd7;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [7:0]  tile_value;
    logic [5:0]  goal_x;
    logic [5:0]  goal_y;
    logic [11:0] step_index;
  } gap_in_t;

  typedef struct packed {
    logic        found;
    logic [12:0] path_length;
    logic [5:0]  step_x;
    logic [5:0]  step_y;
  } gap_out_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] g;
    logic [12:0]      h;
    logic [2:0]       dir;
    logic [CNT_W-1:0] seq;
  } cell_word_t;

  // 7-bit two's complement column step
  function automatic logic [6:0] dir_dx(input logic [2:0] d);
    logic [6:0] r;
    case (d)
      DIR_E, DIR_NE, DIR_SE: r = 7'd1;
      DIR_W, DIR_NW, DIR_SW: r = 7'h7F;
      default:               r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] dir_dy(input logic [2:0] d);
    logic [6:0] r;
    case (d)
      DIR_N, DIR_NE, DIR_NW: r = 7'd1;
      DIR_S, DIR_SE, DIR_SW: r = 7'h7F;
      default:               r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/grid_astar_path_search.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search
// Tile map store and 8-connected A* path search with path read-back.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one command per beat:
//   write tile, search, read path step, or no-op. Every command returns one
//   beat on the out channel (out_valid/out_ready/out_data) with the found
//   flag, the stored path length and, for a read, the requested step.
//   cfg channel writes grid_width, grid_height and blocked_code; always ready.
//   Tile write and no-op answer straight from idle; a read of a stored path
//   step first waits on the registered path store read. A search checks the
//   start and goal tiles, clears the status of every cell, sets up the start
//   cell, then per expansion scans every open entry (one cell memory port,
//   registered reads), picks the best, closes it and visits each of its
//   neighbors inside the grid, and finally walks the path back tile by tile.
//   in_ready is high only in idle with no result pending; a stalled out
//   channel therefore holds off the next command.
//   Reset (rst, synchronous) clears control state, found and path length;
//   then a pass over every cell zeroes the tile map while in_ready stays low.
// ----------------------------------------------------------------------------
module grid_astar_path_search
  import gap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  gap_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output gap_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RD_W   = 5'd1;
  localparam logic [4:0] S_CHK_S  = 5'd2;
  localparam logic [4:0] S_CHK_G  = 5'd3;
  localparam logic [4:0] S_CLR    = 5'd4;
  localparam logic [4:0] S_INIT   = 5'd5;
  localparam logic [4:0] S_SCAN0  = 5'd6;
  localparam logic [4:0] S_SC_RL  = 5'd7;
  localparam logic [4:0] S_SC_RC  = 5'd8;
  localparam logic [4:0] S_SC_CMP = 5'd9;
  localparam logic [4:0] S_PICK   = 5'd10;
  localparam logic [4:0] S_RM     = 5'd11;
  localparam logic [4:0] S_CLOSE  = 5'd12;
  localparam logic [4:0] S_NB     = 5'd13;
  localparam logic [4:0] S_NB_E   = 5'd14;
  localparam logic [4:0] S_BP     = 5'd15;
  localparam logic [4:0] S_BP_W   = 5'd16;
  localparam logic [4:0] S_MCLR   = 5'd17;

  // config
  logic [6:0] grid_width, grid_height;
  logic [7:0] blocked_code;

  // memories
  logic             map_mem  [NUM_CELLS];
  cell_word_t       cell_mem [NUM_CELLS];
  logic [IDX_W-1:0] ol_mem   [NUM_CELLS];
  logic [IDX_W-1:0] path_mem [PATH_DEPTH];

  logic             map_we, map_wdata, map_q;
  logic [IDX_W-1:0] map_waddr, map_raddr;
  logic             cell_we;
  logic [IDX_W-1:0] cell_waddr, cell_raddr;
  cell_word_t       cell_wdata, cell_q;
  logic             ol_we;
  logic [IDX_W-1:0] ol_waddr, ol_raddr, ol_wdata, ol_q;
  logic              path_we;
  logic [PIDX_W-1:0] path_waddr, path_raddr;
  logic [IDX_W-1:0]  path_wdata, path_q;

  // control registers
  logic [4:0]       state, state_next;
  logic             out_valid_next;
  gap_out_t         out_data_next;
  logic             found, found_next;
  logic [12:0]      stored_len, stored_len_next;
  logic [IDX_W-1:0] sidx, sidx_next, gidx, gidx_next;
  logic             st_ok, st_ok_next;
  logic [CNT_W-1:0] open_count, open_count_next;
  logic [CNT_W-1:0] seq_cnt, seq_cnt_next;
  logic [CNT_W-1:0] k, k_next;
  logic [IDX_W-1:0] clr_cnt, clr_cnt_next;
  logic             have, have_next;
  logic [IDX_W-1:0] best_k, best_k_next, best_n, best_n_next;
  logic [IDX_W-1:0] scan_n, scan_n_next;
  logic [13:0]      best_sc, best_sc_next;
  logic [CNT_W-1:0] best_seq, best_seq_next;
  logic [IDX_W-1:0] cur, cur_next;
  logic [CNT_W-1:0] cur_g, cur_g_next;
  logic [2:0]       dir, dir_next;
  logic [IDX_W-1:0] nb_idx, nb_idx_next;
  logic [12:0]      plen, plen_next;

  // combinational helpers
  logic [6:0]  eff_w, eff_h;
  logic [6:0]  nx7, ny7;
  logic [6:0]  bp_dx, bp_dy;
  logic [5:0]  adx, ady, hmin;
  logic [6:0]  hsum;
  logic [12:0] hprod;
  logic [13:0] sc;
  logic [CNT_W-1:0] g_new;
  logic [12:0] rd_pos;
  logic        finish, fin_found;
  logic [5:0]  fin_x, fin_y;
  cell_word_t  w_tmp;

  assign eff_w     = (grid_width  > 7'(MAX_WIDTH))  ? 7'(MAX_WIDTH)  : grid_width;
  assign eff_h     = (grid_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : grid_height;
  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  // neighbor coordinates; -1 wraps to 127 and fails the bounds test
  assign nx7 = {1'b0, cur[XW-1:0]} + dir_dx(dir);
  assign ny7 = {1'b0, cur[IDX_W-1:XW]} + dir_dy(dir);

  // step back toward the parent during the walk-back
  assign bp_dx = dir_dx(cell_q.dir);
  assign bp_dy = dir_dy(cell_q.dir);

  // heuristic unit: (dx+dy)*min(dx,dy)
  assign adx   = (nb_idx[XW-1:0] > gidx[XW-1:0]) ? nb_idx[XW-1:0] - gidx[XW-1:0]
                                                 : gidx[XW-1:0] - nb_idx[XW-1:0];
  assign ady   = (nb_idx[IDX_W-1:XW] > gidx[IDX_W-1:XW])
                 ? nb_idx[IDX_W-1:XW] - gidx[IDX_W-1:XW]
                 : gidx[IDX_W-1:XW] - nb_idx[IDX_W-1:XW];
  assign hmin  = (adx < ady) ? adx : ady;
  assign hsum  = {1'b0, adx} + {1'b0, ady};
  assign hprod = {6'b0, hsum} * {7'b0, hmin};

  assign sc     = {1'b0, cell_q.g} + {1'b0, cell_q.h};
  assign g_new  = cur_g + 1'b1;
  assign rd_pos = stored_len - 13'd1 - {1'b0, in_data.step_index};

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_q <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (ol_we) ol_mem[ol_waddr] <= ol_wdata;
    ol_q <= ol_mem[ol_raddr];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_waddr] <= path_wdata;
    path_q <= path_mem[path_raddr];
  end

  always_comb begin
    state_next      = state;
    found_next      = found;
    stored_len_next = stored_len;
    sidx_next       = sidx;
    gidx_next       = gidx;
    st_ok_next      = st_ok;
    open_count_next = open_count;
    seq_cnt_next    = seq_cnt;
    k_next          = k;
    clr_cnt_next    = clr_cnt;
    have_next       = have;
    best_k_next     = best_k;
    best_n_next     = best_n;
    scan_n_next     = scan_n;
    best_sc_next    = best_sc;
    best_seq_next   = best_seq;
    cur_next        = cur;
    cur_g_next      = cur_g;
    dir_next        = dir;
    nb_idx_next     = nb_idx;
    plen_next       = plen;

    map_we     = 1'b0;
    map_waddr  = {in_data.cell_y, in_data.cell_x};
    map_wdata  = (in_data.tile_value != 8'd0) && (in_data.tile_value != blocked_code);
    map_raddr  = {in_data.cell_y, in_data.cell_x};
    cell_we    = 1'b0;
    cell_waddr = cur;
    cell_wdata = cell_q;
    cell_raddr = cur;
    ol_we      = 1'b0;
    ol_waddr   = best_k;
    ol_wdata   = ol_q;
    ol_raddr   = k[IDX_W-1:0];
    path_we    = 1'b0;
    path_waddr = plen[PIDX_W-1:0];
    path_wdata = cur;
    path_raddr = rd_pos[PIDX_W-1:0];
    w_tmp      = cell_q;

    finish    = 1'b0;
    fin_found = found;
    fin_x     = '0;
    fin_y     = '0;

    unique case (state)
      S_MCLR: begin
        // tile map reads as unwalkable until written
        map_we       = 1'b1;
        map_waddr    = clr_cnt;
        map_wdata    = 1'b0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == IDX_W'(NUM_CELLS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.action)
            ACT_WRITE: begin
              map_we = 1'b1;
              finish = 1'b1;
            end
            ACT_SEARCH: begin
              sidx_next  = {in_data.cell_y, in_data.cell_x};
              gidx_next  = {in_data.goal_y, in_data.goal_x};
              state_next = S_CHK_S;
            end
            ACT_READ: begin
              if ({1'b0, in_data.step_index} < stored_len) state_next = S_RD_W;
              else finish = 1'b1;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_RD_W: begin
        finish = 1'b1;
        fin_x  = path_q[XW-1:0];
        fin_y  = path_q[IDX_W-1:XW];
      end
      S_CHK_S: begin
        map_raddr  = gidx;
        st_ok_next = map_q && ({1'b0, sidx[XW-1:0]} < eff_w)
                     && ({1'b0, sidx[IDX_W-1:XW]} < eff_h);
        state_next = S_CHK_G;
      end
      S_CHK_G: begin
        if (st_ok && map_q && ({1'b0, gidx[XW-1:0]} < eff_w)
            && ({1'b0, gidx[IDX_W-1:XW]} < eff_h)) begin
          clr_cnt_next = '0;
          state_next   = S_CLR;
        end else begin
          finish    = 1'b1;
          fin_found = 1'b0;
        end
      end
      S_CLR: begin
        cell_we           = 1'b1;
        cell_waddr        = clr_cnt;
        cell_wdata        = '0;
        cell_wdata.status = ST_NONE;
        clr_cnt_next      = clr_cnt + 1'b1;
        if (clr_cnt == IDX_W'(NUM_CELLS - 1)) state_next = S_INIT;
      end
      S_INIT: begin
        cell_we           = 1'b1;
        cell_waddr        = sidx;
        cell_wdata        = '0;
        cell_wdata.status = ST_OPEN;
        ol_we             = 1'b1;
        ol_waddr          = '0;
        ol_wdata          = sidx;
        open_count_next   = CNT_W'(1);
        seq_cnt_next      = CNT_W'(1);
        state_next        = S_SCAN0;
      end
      S_SCAN0: begin
        if (open_count == '0) begin
          finish    = 1'b1;
          fin_found = 1'b0;
        end else begin
          k_next     = '0;
          have_next  = 1'b0;
          state_next = S_SC_RL;
        end
      end
      S_SC_RL: state_next = S_SC_RC;
      S_SC_RC: begin
        cell_raddr  = ol_q;
        scan_n_next = ol_q;
        state_next  = S_SC_CMP;
      end
      S_SC_CMP: begin
        if ((17'(sc) < 17'(SCORE_CAP)) && (!have || (sc < best_sc)
            || ((sc == best_sc) && (cell_q.seq > best_seq)))) begin
          have_next     = 1'b1;
          best_k_next   = k[IDX_W-1:0];
          best_n_next   = scan_n;
          best_sc_next  = sc;
          best_seq_next = cell_q.seq;
        end
        k_next     = k + 1'b1;
        state_next = (k + 1'b1 == open_count) ? S_PICK : S_SC_RL;
      end
      S_PICK: begin
        if (!have) begin
          finish    = 1'b1;
          fin_found = 1'b0;
        end else begin
          open_count_next = open_count - 1'b1;
          ol_raddr        = open_count_next[IDX_W-1:0];
          state_next      = S_RM;
        end
      end
      S_RM: begin
        // last entry moves into the hole left by the pick
        ol_we      = 1'b1;
        ol_waddr   = best_k;
        ol_wdata   = ol_q;
        cell_raddr = best_n;
        state_next = S_CLOSE;
      end
      S_CLOSE: begin
        w_tmp        = cell_q;
        w_tmp.status = ST_CLOSED;
        cell_we      = 1'b1;
        cell_waddr   = best_n;
        cell_wdata   = w_tmp;
        cur_next     = best_n;
        cur_g_next   = cell_q.g;
        if (best_n == gidx) begin
          plen_next  = '0;
          state_next = S_BP;
        end else begin
          dir_next   = DIR_N;
          state_next = S_NB;
        end
      end
      S_NB: begin
        if ((nx7 < eff_w) && (ny7 < eff_h)) begin
          nb_idx_next = {ny7[YW-1:0], nx7[XW-1:0]};
          map_raddr   = nb_idx_next;
          cell_raddr  = nb_idx_next;
          state_next  = S_NB_E;
        end else begin
          dir_next   = dir + 1'b1;
          state_next = (dir == DIR_SW) ? S_SCAN0 : S_NB;
        end
      end
      S_NB_E: begin
        if (map_q && (cell_q.status != ST_CLOSED)) begin
          if (cell_q.status == ST_OPEN) begin
            if (g_new < cell_q.g) begin
              w_tmp      = cell_q;
              w_tmp.g    = g_new;
              w_tmp.dir  = dir;
              cell_we    = 1'b1;
              cell_waddr = nb_idx;
              cell_wdata = w_tmp;
            end
          end else begin
            w_tmp.status    = ST_OPEN;
            w_tmp.g         = g_new;
            w_tmp.h         = hprod;
            w_tmp.dir       = dir;
            w_tmp.seq       = seq_cnt;
            cell_we         = 1'b1;
            cell_waddr      = nb_idx;
            cell_wdata      = w_tmp;
            ol_we           = 1'b1;
            ol_waddr        = open_count[IDX_W-1:0];
            ol_wdata        = nb_idx;
            open_count_next = open_count + 1'b1;
            seq_cnt_next    = seq_cnt + 1'b1;
          end
        end
        dir_next   = dir + 1'b1;
        state_next = (dir == DIR_SW) ? S_SCAN0 : S_NB;
      end
      S_BP: begin
        // path kept goal-first; reads index from the far end
        path_we    = 1'b1;
        path_waddr = plen[PIDX_W-1:0];
        path_wdata = cur;
        if (cur == sidx) begin
          stored_len_next = plen + 1'b1;
          finish          = 1'b1;
          fin_found       = 1'b1;
        end else begin
          cell_raddr = cur;
          state_next = S_BP_W;
        end
      end
      S_BP_W: begin
        cur_next   = {cur[IDX_W-1:XW] - bp_dy[YW-1:0],
                      cur[XW-1:0] - bp_dx[XW-1:0]};
        plen_next  = plen + 1'b1;
        state_next = S_BP;
      end
      default: state_next = S_IDLE;
    endcase

    if (finish) begin
      state_next = S_IDLE;
      found_next = fin_found;
    end
    out_valid_next            = finish || (out_valid && !out_ready);
    out_data_next             = out_data;
    if (finish) begin
      out_data_next.found       = fin_found;
      out_data_next.path_length = stored_len_next;
      out_data_next.step_x      = fin_x;
      out_data_next.step_y      = fin_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_MCLR;
      out_valid    <= 1'b0;
      found        <= 1'b0;
      stored_len   <= '0;
      open_count   <= '0;
      clr_cnt      <= '0;
      grid_width   <= 7'd64;
      grid_height  <= 7'd64;
      blocked_code <= 8'd255;
    end else begin
      state      <= state_next;
      out_valid  <= out_valid_next;
      found      <= found_next;
      stored_len <= stored_len_next;
      open_count <= open_count_next;
      clr_cnt    <= clr_cnt_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:   grid_width   <= cfg_data[6:0];
          REG_HEIGHT:  grid_height  <= cfg_data[6:0];
          REG_BLOCKED: blocked_code <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
    sidx     <= sidx_next;
    gidx     <= gidx_next;
    st_ok    <= st_ok_next;
    seq_cnt  <= seq_cnt_next;
    k        <= k_next;
    have     <= have_next;
    best_k   <= best_k_next;
    best_n   <= best_n_next;
    scan_n   <= scan_n_next;
    best_sc  <= best_sc_next;
    best_seq <= best_seq_next;
    cur      <= cur_next;
    cur_g    <= cur_g_next;
    dir      <= dir_next;
    nb_idx   <= nb_idx_next;
    plen     <= plen_next;
  end

`ifndef SYNTHESIS
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an input beat");

  a_no_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");

  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    open_count <= CNT_W'(NUM_CELLS))
    else $error("open list overflow");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    stored_len <= 13'(PATH_DEPTH))
    else $error("stored path longer than path store");
`endif

endmodule
